>>> rtl/core/b2d_pkg.sv
// Shared constants and elaboration-time helpers for the binary to decimal ASCII unit.
package b2d_pkg;

  localparam int DefValueWidth = 32;
  localparam int QueueDepth    = 2;
  localparam int MaxDigits     = 20;
  localparam int BcdDigitW     = 4;
  localparam int CharW         = 6;

  localparam logic [CharW-1:0] AsciiZero = 6'd48;

  // Number of decimal digits in the largest value of the given bit width.
  function automatic int dec_digits(input int width);
    logic [64:0] v;
    int          n;
    v = (65'd1 << width) - 65'd1;
    n = 0;
    for (int i = 0; i < MaxDigits; i++) begin
      if (v != 65'd0) begin
        n = n + 1;
        v = v / 65'd10;
      end
    end
    return n;
  endfunction

endpackage

>>> rtl/core/b2d_front.sv
// Input side: accepts values and holds them in a short queue for the converter.
module b2d_front #(
  parameter int VALUE_WIDTH = b2d_pkg::DefValueWidth,
  parameter int DEPTH       = b2d_pkg::QueueDepth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  logic [VALUE_WIDTH-1:0] value_i,
  output logic                   req_valid_o,
  output logic [VALUE_WIDTH-1:0] req_value_o,
  input  logic                   req_take_i
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [VALUE_WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]        count_q, count_d;
  logic                   wr_en, rd_en;

  assign full        = (count_q == CntW'(DEPTH));
  assign req_valid_o = (count_q != '0);
  assign req_value_o = mem_q[rd_ptr_q];
  assign wr_en       = push && !full;
  assign rd_en       = req_take_i && req_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (wr_en && !rd_en) begin
      count_d = count_q + CntW'(1);
    end else if (rd_en && !wr_en) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= value_i;
    end
  end

endmodule

>>> rtl/core/b2d_back.sv
// Converter: shift-and-add-three to BCD, then sends the digits most significant first.
module b2d_back #(
  parameter int VALUE_WIDTH = b2d_pkg::DefValueWidth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  input  logic [VALUE_WIDTH-1:0]     req_value_i,
  output logic                       req_take_o,
  output logic                       empty,
  input  logic                       pop,
  output logic [b2d_pkg::CharW-1:0]  digit_char_o,
  output logic                       last_digit_o
);

  localparam int NDig = b2d_pkg::dec_digits(VALUE_WIDTH);
  localparam int DW   = b2d_pkg::BcdDigitW;
  localparam int BcdW = DW * NDig;
  localparam int IdxW = (NDig > 1) ? $clog2(NDig) : 1;
  localparam int CntW = $clog2(VALUE_WIDTH + 1);

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StCount,
    StEmit
  } state_e;

  state_e                    state_q;
  logic [VALUE_WIDTH-1:0]    bin_q;
  logic [BcdW-1:0]           bcd_q;
  logic [BcdW-1:0]           bcd_adj;
  logic [CntW-1:0]           bit_cnt_q;
  logic [IdxW-1:0]           dig_idx_q;
  logic [IdxW-1:0]           msd_idx;
  logic                      out_valid_q;
  logic [b2d_pkg::CharW-1:0] out_char_q;
  logic                      out_last_q;
  logic                      out_free;
  logic [DW-1:0]             cur_digit;

  assign empty        = !out_valid_q;
  assign digit_char_o = out_char_q;
  assign last_digit_o = out_last_q;
  assign req_take_o   = (state_q == StIdle) && req_valid_i;
  assign out_free     = !out_valid_q || pop;
  assign cur_digit    = bcd_q[DW*dig_idx_q +: DW];

  // Every digit of five or more gets three added before the shift doubles it.
  always_comb begin
    for (int i = 0; i < NDig; i++) begin
      bcd_adj[DW*i +: DW] = (bcd_q[DW*i +: DW] >= DW'(5)) ?
                            bcd_q[DW*i +: DW] + DW'(3) : bcd_q[DW*i +: DW];
    end
  end

  // Position of the highest non-zero digit; zero itself is one digit.
  always_comb begin
    msd_idx = '0;
    for (int i = 0; i < NDig; i++) begin
      if (bcd_q[DW*i +: DW] != '0) begin
        msd_idx = IdxW'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      bin_q       <= '0;
      bcd_q       <= '0;
      bit_cnt_q   <= '0;
      dig_idx_q   <= '0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (pop && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (req_valid_i) begin
            bin_q     <= req_value_i;
            bcd_q     <= '0;
            bit_cnt_q <= CntW'(VALUE_WIDTH);
            state_q   <= StConv;
          end
        end
        StConv: begin
          bcd_q     <= {bcd_adj[BcdW-2:0], bin_q[VALUE_WIDTH-1]};
          bin_q     <= bin_q << 1;
          bit_cnt_q <= bit_cnt_q - CntW'(1);
          if (bit_cnt_q == CntW'(1)) begin
            state_q <= StCount;
          end
        end
        StCount: begin
          dig_idx_q <= msd_idx;
          state_q   <= StEmit;
        end
        StEmit: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_char_q  <= b2d_pkg::AsciiZero + {{(b2d_pkg::CharW-DW){1'b0}}, cur_digit};
            out_last_q  <= (dig_idx_q == '0);
            if (dig_idx_q == '0) begin
              state_q <= StIdle;
            end else begin
              dig_idx_q <= dig_idx_q - IdxW'(1);
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/binary_to_decimal_ascii_unit.sv
// Top level of the binary to decimal ASCII unit: input queue and converter.
//
//   Channel   Handshake      Payload
//   input     push / full    value_i (VALUE_WIDTH bits, unsigned)
//   result    empty / pop    digit_char_o (6 bits), last_digit_o (1 bit)
//
// In the converter a value is loaded while idle, shifted bit by bit through the
// shift-and-add-three loop, its leading digit is found in the count state, and
// its digits are then sent one by one, giving 1 to 10 digit beats at 32 bits.
// The input queue holds two values, so pushes continue while the converter works.
// Reset clears the queue and the converter; a withheld pop backs up to full.
module binary_to_decimal_ascii_unit #(
  parameter int VALUE_WIDTH = b2d_pkg::DefValueWidth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic [VALUE_WIDTH-1:0]     value_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [b2d_pkg::CharW-1:0]  digit_char_o,
  output logic                       last_digit_o
);

  logic                   req_valid;
  logic [VALUE_WIDTH-1:0] req_value;
  logic                   req_take;

  b2d_front #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .DEPTH      (b2d_pkg::QueueDepth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .value_i    (value_i),
    .req_valid_o(req_valid),
    .req_value_o(req_value),
    .req_take_i (req_take)
  );

  b2d_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_value_i (req_value),
    .req_take_o  (req_take),
    .empty       (empty),
    .pop         (pop),
    .digit_char_o(digit_char_o),
    .last_digit_o(last_digit_o)
  );

endmodule

>>> bench/testbench.sv
// Self-checking testbench for the binary to decimal ASCII unit.
`timescale 1ns / 100ps

module testbench;

  localparam int ValueW = b2d_pkg::DefValueWidth;
  localparam int CharW  = b2d_pkg::CharW;
  localparam int IdlePct = 25;
  localparam int RandomValues = 184;
  localparam int SettleCycles = 60;
  localparam int MaxReports = 10;
  localparam logic [CharW-1:0] CharZero = b2d_pkg::AsciiZero;

  typedef struct {
    logic [ValueW-1:0] val;
    bit                drain;
  } value_job_t;

  typedef struct {
    logic [CharW-1:0] ch;
    logic             last;
  } digit_beat_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              push = 1'b0;
  logic              full;
  logic [ValueW-1:0] value = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic [CharW-1:0]  digit_char;
  logic              last_digit;

  value_job_t  values_to_send[$];
  digit_beat_t digits_due[$];
  int          values_taken = 0;
  int          mismatches = 0;
  bit          accepted;
  bit          idle_now;
  digit_beat_t seen_beat;
  digit_beat_t due_beat;

  binary_to_decimal_ascii_unit #(.VALUE_WIDTH(ValueW)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .value_i      (value),
    .empty        (empty),
    .pop          (pop),
    .digit_char_o (digit_char),
    .last_digit_o (last_digit)
  );

  always #5 clk_i = ~clk_i;

  // Both sides run without idling while this many values have been taken.
  function automatic bit calm_stretch();
    return values_taken >= 120 && values_taken < 170;
  endfunction

  // Decimal digits of the value, most significant first, one beat per digit.
  task automatic queue_decimal_digits(input logic [ValueW-1:0] v);
    logic [3:0]      rev_digits[20];
    int              n;
    longint unsigned rest;
    digit_beat_t     beat;
    n = 0;
    rest = longint'(v);
    do begin
      rev_digits[n] = 4'(rest % 10);
      rest = rest / 10;
      n++;
    end while (rest != 0);
    for (int k = n - 1; k >= 0; k--) begin
      beat.ch = CharZero + CharW'(rev_digits[k]);
      beat.last = (k == 0);
      digits_due.push_back(beat);
    end
  endtask

  task automatic add_value(input logic [ValueW-1:0] v, input bit drain_first);
    value_job_t job;
    job.val = v;
    job.drain = drain_first;
    values_to_send.push_back(job);
  endtask

  // Random value of a random digit count, so that short numbers are as common as long ones.
  function automatic logic [ValueW-1:0] value_of_random_length();
    longint unsigned lo;
    longint unsigned hi;
    int              ndig;
    ndig = $urandom_range(1, 10);
    lo = 1;
    for (int i = 1; i < ndig; i++) lo = lo * 10;
    hi = lo * 10 - 1;
    if (ndig == 1) lo = 0;
    if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
    return ValueW'(lo + (longint'($urandom) % (hi - lo + 1)));
  endfunction

  // Driver: a beat held back by full stays on the ports unchanged.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
      value <= '0;
    end else begin
      accepted = push && !full;
      if (accepted) begin
        queue_decimal_digits(value);
        values_taken++;
      end
      if (!(push && !accepted)) begin
        idle_now = !calm_stretch() && ($urandom_range(0, 99) < IdlePct);
        if (values_to_send.size() != 0 && !idle_now &&
            !(values_to_send[0].drain && digits_due.size() != 0)) begin
          push <= 1'b1;
          value <= values_to_send[0].val;
          values_to_send.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each digit beat with the oldest one predicted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        seen_beat.ch = digit_char;
        seen_beat.last = last_digit;
        if (digits_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("unexpected digit beat: char %0d last %0b", seen_beat.ch, seen_beat.last);
        end else begin
          due_beat = digits_due.pop_front();
          if (seen_beat.ch !== due_beat.ch || seen_beat.last !== due_beat.last) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display("digit mismatch: expected char %0d last %0b, got char %0d last %0b",
                       due_beat.ch, due_beat.last, seen_beat.ch, seen_beat.last);
          end
        end
      end
      pop <= calm_stretch() || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  initial begin
    longint unsigned power;
    // Edge values, every digit count boundary and alternating bit patterns.
    add_value(32'd0, 1'b0);
    add_value(32'd1, 1'b0);
    add_value(32'd9, 1'b0);
    power = 10;
    for (int k = 1; k < 10; k++) begin
      add_value(ValueW'(power), 1'b0);
      add_value(ValueW'(power - 1), 1'b0);
      power = power * 10;
    end
    add_value(32'hFFFF_FFFF, 1'b0);
    add_value(32'hFFFF_FFFE, 1'b0);
    add_value(32'h8000_0000, 1'b0);
    add_value(32'h5555_5555, 1'b0);
    add_value(32'hAAAA_AAAA, 1'b0);
    for (int i = 0; i < RandomValues; i++) begin
      if (i % 3 == 0)
        add_value(ValueW'($urandom), i == 0 || i == 90);
      else
        add_value(value_of_random_length(), i == 0 || i == 90);
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i); while (values_to_send.size() != 0 || push);
    do @(posedge clk_i); while (digits_due.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0 && digits_due.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/b2d_pkg.sv
rtl/core/b2d_front.sv
rtl/core/b2d_back.sv
rtl/core/binary_to_decimal_ascii_unit.sv
bench/testbench.sv
